// ===== rtl/system_register_table_access_top_assert.svh =====
// Assertion macros shared by the register table logic.
`ifndef SYSTEM_REGISTER_TABLE_ACCESS_TOP_ASSERT_SVH
`define SYSTEM_REGISTER_TABLE_ACCESS_TOP_ASSERT_SVH

// Condition holds in the same cycle as the trigger.
`define SRTA_ASSERT_NOW(lbl, ck, rstn, trig, cond) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (trig) |-> (cond)) \
		else $error("assertion failed");

// Condition holds in the cycle after the trigger.
`define SRTA_ASSERT_NEXT(lbl, ck, rstn, trig, cond) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (trig) |=> (cond)) \
		else $error("assertion failed");

`endif

// ===== rtl/srta_pkg.sv =====
package srta_pkg;

	localparam int DEFAULT_TABLE_DEPTH = 256;

	localparam logic [2:0] ST_READ_DONE  = 3'd0;
	localparam logic [2:0] ST_WRITE_DONE = 3'd1;
	localparam logic [2:0] ST_FULL       = 3'd2;
	localparam logic [2:0] ST_UNKNOWN    = 3'd3;
	localparam logic [2:0] ST_MAINT      = 3'd4;
	localparam logic [2:0] ST_SPECIAL    = 3'd5;

	localparam logic [1:0] FN_EXEC = 2'd0;
	localparam logic [1:0] FN_SET  = 2'd1;
	localparam logic [1:0] FN_GET  = 2'd2;

	localparam logic [15:0] KEY_MPIDR = 16'hC005;
	localparam logic [15:0] KEY_COUNT = 16'hC298;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] instruction;
		logic [63:0] write_value;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] read_data;
		logic        dest_write;
		logic [4:0]  dest_reg;
		logic        invalidate_request;
	} rsp_t;

	// Lookup token handed from cell to cell.
	typedef struct packed {
		logic        active;
		logic        wr;
		logic [15:0] key;
		logic [63:0] wdata;
		logic        hit;
		logic        alloc;
		logic [63:0] old;
	} tok_t;

	function automatic logic [63:0] init_value(input logic [15:0] key);
		if (key == KEY_MPIDR) begin
			return 64'h0000_0000_8100_0000;
		end else if (key == KEY_COUNT) begin
			return 64'd1;
		end
		return 64'd0;
	endfunction

endpackage

// ===== rtl/srta_cell.sv =====
module srta_cell #(
	parameter int TABLE_DEPTH = srta_pkg::DEFAULT_TABLE_DEPTH,
	parameter int IDX = 0
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [$clog2(TABLE_DEPTH+1)-1:0] count,
	input  srta_pkg::tok_t                   tok_in,
	output srta_pkg::tok_t                   tok_out
);
	localparam int CW = $clog2(TABLE_DEPTH+1);
	localparam logic [CW-1:0] MY_IDX = CW'(IDX);

	logic [15:0] key_q;
	logic [63:0] value_q;
	srta_pkg::tok_t tok_q;
	logic match, alloc;
	logic [63:0] init;

	// Entries below the fill count hold live keys; the one at the count is the next free.
	assign match = tok_in.active && !tok_in.hit && (MY_IDX < count) && (key_q == tok_in.key);
	assign alloc = tok_in.active && !tok_in.hit && (MY_IDX == count);
	assign init  = srta_pkg::init_value(tok_in.key);

	always_ff @(posedge clk) begin
		if (alloc) begin
			key_q <= tok_in.key;
		end
		if ((match || alloc) && tok_in.wr) begin
			value_q <= tok_in.wdata;
		end else if (alloc) begin
			value_q <= init;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_in;
			if (match) begin
				tok_q.hit <= 1'b1;
				tok_q.old <= value_q;
			end else if (alloc) begin
				tok_q.hit   <= 1'b1;
				tok_q.alloc <= 1'b1;
				tok_q.old   <= init;
			end
		end
	end

	assign tok_out = tok_q;
endmodule

// ===== rtl/system_register_table_access_top.sv =====
// Table accesses (MRS, MSR, host set/get) register the lookup token, then it walks the row of cells
// one cell per cycle; done follows when it leaves the last cell. Other forms raise done in the cycle after start.
// A table access holds busy high until done, so no new request is taken while the token walks;
// other forms leave busy low and can be taken every cycle.
// The result is shown for one cycle on done; the receiver cannot stall it.
// Asynchronous reset empties the table (fill count zero) and clears kernel_stage.
module system_register_table_access_top #(
	parameter int TABLE_DEPTH = srta_pkg::DEFAULT_TABLE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  srta_pkg::req_t request,
	output logic           done,
	output srta_pkg::rsp_t result,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic           cfg_data
);
	`include "system_register_table_access_top_assert.svh"

	localparam int CW = $clog2(TABLE_DEPTH+1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_WALK = 2'b10
	} state_t;

	state_t state_q;
	logic ks_q;
	logic [CW-1:0] count_q;
	srta_pkg::tok_t launch_q;
	srta_pkg::tok_t tok [TABLE_DEPTH+1];
	srta_pkg::rsp_t res_q;
	logic done_q;
	logic rd_q, host_q, stage1_q;
	logic [4:0] rt_q;

	logic accept;
	logic [31:0] ins, m, cls;
	logic [4:0] rt;
	logic special, tlb, maint, stage1, is_mrs, is_msr;
	srta_pkg::tok_t tend;

	assign accept = start && !busy;
	assign busy = (state_q == S_WALK);
	assign cfg_ready = 1'b1;

	assign ins = request.instruction;
	assign m   = ins & 32'hffffffe0;
	assign cls = ins & 32'hfff00000;
	assign rt  = ins[4:0];
	assign special = (m == 32'hd5384240) || (ins == 32'hd50040bf) || (ins == 32'hd50041bf) ||
		(m == 32'hd5184200) || (m == 32'hd5384200);
	assign tlb = (cls == 32'hd5000000) && (ins[15:12] == 4'd8);
	assign maint = (ins == 32'hd50344ff) || (ins == 32'hd50e871f) || (ins == 32'hd508751f) ||
		(m == 32'hd50b7520) || (m == 32'hd5087620) || (m == 32'hd50b7a20) ||
		(m == 32'hd50b7b20) || (m == 32'hd50b7e20) || tlb;
	assign stage1 = (m == 32'hd5181000) || (m == 32'hd5182000) || (m == 32'hd5182020) ||
		(m == 32'hd5182040);
	assign is_mrs = (cls == 32'hd5300000);
	assign is_msr = (cls == 32'hd5100000);

	assign tok[0] = launch_q;
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_row
		srta_cell #(.TABLE_DEPTH(TABLE_DEPTH), .IDX(i)) u_cell (
			.clk(clk), .arst_n(arst_n), .count(count_q), .tok_in(tok[i]), .tok_out(tok[i+1])
		);
	end
	assign tend = tok[TABLE_DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ks_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			ks_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			launch_q <= '0;
			done_q   <= 1'b0;
		end else begin
			launch_q.active <= 1'b0;
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						launch_q.key <= ins[20:5];
						if (request.func == srta_pkg::FN_SET || request.func == srta_pkg::FN_GET) begin
							launch_q.active <= 1'b1;
							launch_q.wr     <= (request.func == srta_pkg::FN_SET);
							launch_q.wdata  <= request.write_value;
							state_q <= S_WALK;
						end else if (request.func == srta_pkg::FN_EXEC && !special && !maint &&
							(is_mrs || is_msr)) begin
							launch_q.active <= 1'b1;
							launch_q.wr     <= is_msr;
							launch_q.wdata  <= (rt == 5'd31) ? 64'd0 : request.write_value;
							state_q <= S_WALK;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				S_WALK: begin
					if (tend.active) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
						if (tend.alloc) begin
							count_q <= count_q + CW'(1);
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rt_q     <= rt;
			host_q   <= (request.func != srta_pkg::FN_EXEC);
			rd_q     <= (request.func == srta_pkg::FN_GET) ||
				((request.func == srta_pkg::FN_EXEC) && is_mrs);
			stage1_q <= stage1;
			res_q.read_data          <= 64'd0;
			res_q.dest_write         <= 1'b0;
			res_q.dest_reg           <= rt;
			res_q.invalidate_request <= 1'b0;
			res_q.status             <= srta_pkg::ST_UNKNOWN;
			if (request.func == srta_pkg::FN_EXEC) begin
				if (special) begin
					res_q.status <= srta_pkg::ST_SPECIAL;
				end else if (maint) begin
					res_q.status             <= srta_pkg::ST_MAINT;
					res_q.invalidate_request <= ks_q && tlb;
				end
			end
		end else if (busy && tend.active) begin
			if (!tend.hit) begin
				res_q.status <= srta_pkg::ST_FULL;
			end else if (rd_q) begin
				res_q.status     <= srta_pkg::ST_READ_DONE;
				res_q.read_data  <= tend.old;
				res_q.dest_write <= !host_q && (rt_q != 5'd31);
			end else begin
				res_q.status <= srta_pkg::ST_WRITE_DONE;
				res_q.invalidate_request <= !host_q && ks_q && stage1_q && (tend.wdata != tend.old);
			end
		end
	end

	assign done   = done_q;
	assign result = res_q;

	`SRTA_ASSERT_NOW(a_done_not_busy, clk, arst_n, done, !busy)
	`SRTA_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= FULL_COUNT)
	`SRTA_ASSERT_NEXT(a_launch_busy, clk, arst_n, launch_q.active, busy)
	`SRTA_ASSERT_NOW(a_full_no_alloc, clk, arst_n, tend.active && tend.alloc, count_q != FULL_COUNT)
endmodule
